// ----- rtl/rgb_conv3x3_threshold_defines.svh -----
// Assertion macros shared by the rgb_conv3x3_threshold RTL.
`ifndef RGB_CONV3X3_THRESHOLD_DEFINES_SVH
`define RGB_CONV3X3_THRESHOLD_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RCT_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rct: same-cycle check failed");
`define RCT_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rct: next-cycle check failed");
`else
`define RCT_ASSERT_IMPLY(label, clk, rst, cond, expr)
`define RCT_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// ----- rtl/rct_pkg.sv -----
// Package: constants, types and helpers of the RGB 3x3 convolution block.
package rct_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int COMPONENT_BITS = 8;
   localparam int COEF_BITS      = 16;
   localparam int FRAC_BITS      = 8;
   localparam int KERNEL_TAPS    = 3;

   localparam int PIX_BITS   = KERNEL_TAPS * COMPONENT_BITS;
   localparam int CSUM_BITS  = COMPONENT_BITS + 2;
   localparam int PROD_BITS  = CSUM_BITS + 1 + COEF_BITS;
   localparam int ACC_BITS   = PROD_BITS + 4;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS = 11;
   localparam int ROW_BITS   = 16;
   localparam int ROWX_BITS  = ROW_BITS + 1;
   localparam int VAL_BITS   = 21;
   localparam int MAX_BITS   = VAL_BITS - 1;
   localparam int KROW_BITS  = KERNEL_TAPS * COEF_BITS;

   localparam int CSR_DATA_BITS = KROW_BITS;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [KROW_BITS-1:0] KERNEL_TOP_RESET    = 48'd280379743338240;
   localparam logic [KROW_BITS-1:0] KERNEL_MID_RESET    = 48'd0;
   localparam logic [KROW_BITS-1:0] KERNEL_BOTTOM_RESET = 48'd2199056810496;

   localparam logic signed [VAL_BITS-1:0] VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
   localparam logic signed [VAL_BITS-1:0] VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_KERNEL_TOP,
      CSR_KERNEL_MID,
      CSR_KERNEL_BOTTOM,
      CSR_THRESHOLD,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT
   } csr_index_type;

   typedef logic [PIX_BITS-1:0] pixel_type;
   typedef pixel_type [KERNEL_TAPS-1:0][KERNEL_TAPS-1:0] window_type;
   typedef logic [KERNEL_TAPS-1:0][KROW_BITS-1:0] kernel_type;

   typedef struct packed {
      logic                interior;
      logic                last;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
   } meta_type;

   typedef struct packed {
      logic     valid;
      meta_type meta;
   } stage_type;

   function automatic logic [CSUM_BITS-1:0] csum(input pixel_type p);
      logic [CSUM_BITS-1:0] acc;
      acc = '0;
      for (int k = 0; k < KERNEL_TAPS; k++) begin
         acc = acc + CSUM_BITS'(p[k*COMPONENT_BITS +: COMPONENT_BITS]);
      end
      return acc;
   endfunction

endpackage

// ----- rtl/rct_if.sv -----
// Stream interfaces: pixel request channel and filtered result channel.
interface rct_req_if;
   logic                             valid;
   logic                             ready;
   logic [rct_pkg::COMPONENT_BITS-1:0] red;
   logic [rct_pkg::COMPONENT_BITS-1:0] green;
   logic [rct_pkg::COMPONENT_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rct_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rct_pkg::VAL_BITS-1:0] filtered_value;
   logic [rct_pkg::ROW_BITS-1:0]      center_row;
   logic [rct_pkg::COL_BITS-1:0]      center_col;
   logic [rct_pkg::MAX_BITS-1:0]      frame_max;
   logic                              frame_last;

   modport source (output valid, output filtered_value, output center_row,
                   output center_col, output frame_max, output frame_last, input ready);
   modport sink   (input valid, input filtered_value, input center_row,
                   input center_col, input frame_max, input frame_last, output ready);
endinterface

// ----- rtl/rct_ram.sv -----
// Generic simple dual-port RAM with registered read.
module rct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/rct_window.sv -----
// Raster counters, two-line buffer and 3x3 pixel window.
`include "rgb_conv3x3_threshold_defines.svh"
module rct_window (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  rct_pkg::pixel_type             in_pixel,
   input  logic [rct_pkg::WIDTH_BITS-1:0] image_width,
   input  logic [rct_pkg::ROW_BITS-1:0]   image_height,
   output rct_pkg::stage_type             win_stage,
   output rct_pkg::window_type            win_pix,
   input  logic                           win_ready
);

   logic [rct_pkg::COL_BITS-1:0]   col_ff, col_in;
   logic [rct_pkg::ROW_BITS-1:0]   row_ff, row_in;
   logic [rct_pkg::WIDTH_BITS-1:0] w_eff;
   logic [rct_pkg::ROW_BITS-1:0]   h_eff;
   logic                           end_row, end_frame, interior;
   logic                           accept, s2_free, s1_adv;

   logic                s1_valid_ff;
   rct_pkg::meta_type   s1_meta_ff;
   rct_pkg::pixel_type  s1_pixel_ff;
   logic                s2_valid_ff;
   rct_pkg::meta_type   s2_meta_ff;
   rct_pkg::window_type win_ff;

   logic                         ram_re, ram_we;
   logic [rct_pkg::COL_BITS-1:0] ram_raddr, ram_waddr;
   logic [2*rct_pkg::PIX_BITS-1:0] ram_wdata, ram_rdata;
   rct_pkg::pixel_type           line_top, line_mid;

   always_comb begin
      if (image_width < rct_pkg::WIDTH_BITS'(rct_pkg::KERNEL_TAPS)) begin
         w_eff = rct_pkg::WIDTH_BITS'(rct_pkg::KERNEL_TAPS);
      end else if (image_width > rct_pkg::WIDTH_BITS'(rct_pkg::MAX_WIDTH)) begin
         w_eff = rct_pkg::WIDTH_BITS'(rct_pkg::MAX_WIDTH);
      end else begin
         w_eff = image_width;
      end
      if (image_height < rct_pkg::ROW_BITS'(rct_pkg::KERNEL_TAPS)) begin
         h_eff = rct_pkg::ROW_BITS'(rct_pkg::KERNEL_TAPS);
      end else begin
         h_eff = image_height;
      end
   end

   assign end_row   = (rct_pkg::WIDTH_BITS'(col_ff) + rct_pkg::WIDTH_BITS'(1)) >= w_eff;
   assign end_frame = end_row &&
                      ((rct_pkg::ROWX_BITS'(row_ff) + rct_pkg::ROWX_BITS'(1)) >=
                       rct_pkg::ROWX_BITS'(h_eff));
   assign interior  = (row_ff >= rct_pkg::ROW_BITS'(rct_pkg::KERNEL_TAPS - 1)) &&
                      (col_ff >= rct_pkg::COL_BITS'(rct_pkg::KERNEL_TAPS - 1));

   always_comb begin
      col_in = col_ff + rct_pkg::COL_BITS'(1);
      row_in = row_ff;
      if (end_frame) begin
         col_in = '0;
         row_in = '0;
      end else if (end_row) begin
         col_in = '0;
         row_in = row_ff + rct_pkg::ROW_BITS'(1);
      end
   end

   assign s2_free  = !s2_valid_ff || win_ready;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign in_ready = !s1_valid_ff || s2_free;
   assign accept   = in_valid && in_ready;

   // line word: newest stored row in the upper half, older row in the lower half
   assign ram_re    = accept;
   assign ram_raddr = col_ff;
   assign ram_we    = s1_adv;
   assign ram_waddr = s1_meta_ff.col;
   assign line_top  = ram_rdata[rct_pkg::PIX_BITS-1:0];
   assign line_mid  = ram_rdata[2*rct_pkg::PIX_BITS-1:rct_pkg::PIX_BITS];
   assign ram_wdata = {s1_pixel_ff, line_mid};

   rct_ram #(
      .WIDTH (2 * rct_pkg::PIX_BITS),
      .DEPTH (rct_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (in_ready) begin
            s1_valid_ff <= accept;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff         <= in_pixel;
         s1_meta_ff.interior <= interior;
         s1_meta_ff.last     <= end_frame;
         s1_meta_ff.row      <= row_ff - rct_pkg::ROW_BITS'(1);
         s1_meta_ff.col      <= col_ff;
      end
      if (s1_adv) begin
         s2_meta_ff     <= s1_meta_ff;
         s2_meta_ff.col <= s1_meta_ff.col - rct_pkg::COL_BITS'(1);
         for (int a = 0; a < rct_pkg::KERNEL_TAPS; a++) begin
            win_ff[a][0] <= win_ff[a][1];
            win_ff[a][1] <= win_ff[a][2];
         end
         win_ff[0][2] <= line_top;
         win_ff[1][2] <= line_mid;
         win_ff[2][2] <= s1_pixel_ff;
      end
   end

   assign win_stage = '{valid: s2_valid_ff, meta: s2_meta_ff};
   assign win_pix   = win_ff;

   `RCT_ASSERT_IMPLY(a_ram_no_collision, clock, reset, ram_re && ram_we, ram_raddr != ram_waddr)
   `RCT_ASSERT_IMPLY(a_last_is_interior, clock, reset, s2_valid_ff && s2_meta_ff.last, s2_meta_ff.interior)
   `RCT_ASSERT_NEXT(a_s1_held_on_stall, clock, reset, s1_valid_ff && !s2_free, s1_valid_ff && $stable(ram_rdata))

endmodule

// ----- rtl/rct_mac.sv -----
// Kernel products, channel sum, threshold, truncation and frame maximum.
`include "rgb_conv3x3_threshold_defines.svh"
module rct_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  rct_pkg::stage_type                  win_stage,
   input  rct_pkg::window_type                 win_pix,
   output logic                                win_ready,
   input  rct_pkg::kernel_type                 kernel,
   input  logic signed [rct_pkg::VAL_BITS-1:0] threshold,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [rct_pkg::VAL_BITS-1:0] out_value,
   output logic [rct_pkg::ROW_BITS-1:0]        out_row,
   output logic [rct_pkg::COL_BITS-1:0]        out_col,
   output logic [rct_pkg::MAX_BITS-1:0]        out_max,
   output logic                                out_last
);

   localparam int K = rct_pkg::KERNEL_TAPS;

   logic adv_out, s4_ready, s3_ready, out_load;

   logic signed [rct_pkg::PROD_BITS-1:0] prod_in [K][K];
   logic signed [rct_pkg::PROD_BITS-1:0] prod_ff [K][K];
   logic                                 s3_valid_ff;
   rct_pkg::meta_type                    s3_meta_ff;

   logic signed [rct_pkg::ACC_BITS-1:0] sum_in, sum_ff;
   logic                                s4_valid_ff;
   rct_pkg::meta_type                   s4_meta_ff;

   logic signed [rct_pkg::ACC_BITS-1:0] thr_scaled, rounded, quot;
   logic signed [rct_pkg::VAL_BITS-1:0] val;
   logic [rct_pkg::MAX_BITS-1:0]        max_ff, max_in;

   logic                                out_valid_ff;
   logic signed [rct_pkg::VAL_BITS-1:0] out_value_ff;
   logic [rct_pkg::ROW_BITS-1:0]        out_row_ff;
   logic [rct_pkg::COL_BITS-1:0]        out_col_ff;
   logic [rct_pkg::MAX_BITS-1:0]        out_max_ff;
   logic                                out_last_ff;

   assign adv_out   = !out_valid_ff || out_ready;
   assign s4_ready  = !s4_valid_ff || adv_out;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign win_ready = s3_ready;
   assign out_load  = s4_valid_ff && adv_out;

   always_comb begin
      for (int a = 0; a < K; a++) begin
         for (int b = 0; b < K; b++) begin
            prod_in[a][b] = $signed(kernel[a][b*rct_pkg::COEF_BITS +: rct_pkg::COEF_BITS]) *
                            $signed({1'b0, rct_pkg::csum(win_pix[a][b])});
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int a = 0; a < K; a++) begin
         for (int b = 0; b < K; b++) begin
            sum_in = sum_in + rct_pkg::ACC_BITS'(prod_ff[a][b]);
         end
      end
   end

   // exact compare against threshold (zero below it), then divide by 256 toward zero and saturate
   always_comb begin
      thr_scaled = rct_pkg::ACC_BITS'($signed({threshold, {rct_pkg::FRAC_BITS{1'b0}}}));
      if (sum_ff[rct_pkg::ACC_BITS-1]) begin
         rounded = sum_ff + rct_pkg::ACC_BITS'(2**rct_pkg::FRAC_BITS - 1);
      end else begin
         rounded = sum_ff;
      end
      quot = rounded >>> rct_pkg::FRAC_BITS;
      if (sum_ff < thr_scaled) begin
         val = '0;
      end else if (quot > rct_pkg::ACC_BITS'(rct_pkg::VAL_MAX)) begin
         val = rct_pkg::VAL_MAX;
      end else if (quot < rct_pkg::ACC_BITS'(rct_pkg::VAL_MIN)) begin
         val = rct_pkg::VAL_MIN;
      end else begin
         val = quot[rct_pkg::VAL_BITS-1:0];
      end
      max_in = max_ff;
      if (!val[rct_pkg::VAL_BITS-1] && (val[rct_pkg::MAX_BITS-1:0] > max_ff)) begin
         max_in = val[rct_pkg::MAX_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ff       <= '0;
      end else begin
         if (s3_ready) begin
            s3_valid_ff <= win_stage.valid && win_stage.meta.interior;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (adv_out) begin
            out_valid_ff <= s4_valid_ff;
         end
         if (out_load) begin
            max_ff <= s4_meta_ff.last ? '0 : max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         prod_ff    <= prod_in;
         s3_meta_ff <= win_stage.meta;
      end
      if (s4_ready) begin
         sum_ff     <= sum_in;
         s4_meta_ff <= s3_meta_ff;
      end
      if (out_load) begin
         out_value_ff <= val;
         out_row_ff   <= s4_meta_ff.row;
         out_col_ff   <= s4_meta_ff.col;
         out_max_ff   <= max_in;
         out_last_ff  <= s4_meta_ff.last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_row   = out_row_ff;
   assign out_col   = out_col_ff;
   assign out_max   = out_max_ff;
   assign out_last  = out_last_ff;

   `RCT_ASSERT_IMPLY(a_max_covers_value, clock, reset, out_valid_ff && !out_value_ff[rct_pkg::VAL_BITS-1], out_max_ff >= out_value_ff[rct_pkg::MAX_BITS-1:0])
   `RCT_ASSERT_IMPLY(a_value_meets_threshold, clock, reset, out_valid_ff && (out_value_ff != '0), out_value_ff >= threshold)
   `RCT_ASSERT_NEXT(a_max_monotonic, clock, reset, !(out_load && s4_meta_ff.last), max_ff >= $past(max_ff))

endmodule

// ----- rtl/rgb_conv3x3_threshold.sv -----
// Top level: RGB 3x3 convolution with threshold over a raster pixel stream.
// Pipeline: a pixel transfer passes through the line RAM read, window load, kernel
//   products, channel sum, and threshold and output register stages in that order.
// Throughput: one pixel per clock; the only stall is back-pressure on rsp_stream.
// Reset (synchronous): clears counters, frame maximum, stage valids and restores
//   register defaults; line buffer and window contents are left as they are.
module rgb_conv3x3_threshold (
   input  logic                              clock,
   input  logic                              reset,
   rct_req_if.sink                           req_stream,
   rct_rsp_if.source                         rsp_stream,
   input  logic                              csr_we,
   input  logic [rct_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rct_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   rct_pkg::kernel_type                 kernel_ff;
   logic signed [rct_pkg::VAL_BITS-1:0] threshold_ff;
   logic [rct_pkg::WIDTH_BITS-1:0]      width_ff;
   logic [rct_pkg::ROW_BITS-1:0]        height_ff;

   rct_pkg::stage_type  win_stage;
   rct_pkg::window_type win_pix;
   logic                win_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0] <= rct_pkg::KERNEL_TOP_RESET;
         kernel_ff[1] <= rct_pkg::KERNEL_MID_RESET;
         kernel_ff[2] <= rct_pkg::KERNEL_BOTTOM_RESET;
         threshold_ff <= '0;
         width_ff     <= rct_pkg::WIDTH_BITS'(rct_pkg::KERNEL_TAPS);
         height_ff    <= rct_pkg::ROW_BITS'(rct_pkg::KERNEL_TAPS);
      end else if (csr_we) begin
         case (rct_pkg::csr_index_type'(csr_index))
            rct_pkg::CSR_KERNEL_TOP: begin
               kernel_ff[0] <= csr_wdata[rct_pkg::KROW_BITS-1:0];
            end
            rct_pkg::CSR_KERNEL_MID: begin
               kernel_ff[1] <= csr_wdata[rct_pkg::KROW_BITS-1:0];
            end
            rct_pkg::CSR_KERNEL_BOTTOM: begin
               kernel_ff[2] <= csr_wdata[rct_pkg::KROW_BITS-1:0];
            end
            rct_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_wdata[rct_pkg::VAL_BITS-1:0];
            end
            rct_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[rct_pkg::WIDTH_BITS-1:0];
            end
            rct_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[rct_pkg::ROW_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   rct_window u_window (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_stream.valid),
      .in_ready     (req_stream.ready),
      .in_pixel     ({req_stream.blue, req_stream.green, req_stream.red}),
      .image_width  (width_ff),
      .image_height (height_ff),
      .win_stage    (win_stage),
      .win_pix      (win_pix),
      .win_ready    (win_ready)
   );

   rct_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .win_stage (win_stage),
      .win_pix   (win_pix),
      .win_ready (win_ready),
      .kernel    (kernel_ff),
      .threshold (threshold_ff),
      .out_valid (rsp_stream.valid),
      .out_ready (rsp_stream.ready),
      .out_value (rsp_stream.filtered_value),
      .out_row   (rsp_stream.center_row),
      .out_col   (rsp_stream.center_col),
      .out_max   (rsp_stream.frame_max),
      .out_last  (rsp_stream.frame_last)
   );

endmodule
